// ===== design/sus_pkg.sv =====
// Shared types and codes for the sorted unique set.
package sus_pkg;

  // Width of the entry count field on the result channel
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_RD     = 3'd1,
    S_EVAL   = 3'd2,
    S_SH_RD  = 3'd3,
    S_SH_WR  = 3'd4
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    idx_inc;
    logic    wr_new;
    logic    wr_carry;
    logic    wr_back;
    logic    finish;
    status_t code;
    cnt_op_t cnt_op;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_valid;
    logic is_remove;
    logic at_end;
    logic eq;
    logic gt;
    logic full;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== design/sus_if.sv =====
// Request and result channel interfaces for the sorted unique set.
interface sus_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sus_out_if import sus_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== design/sus_datapath.sv =====
// Datapath: entry memory, scan index, count, compare and result register.
module sus_datapath import sus_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            ctl,
  output dp_status_t         st,
  input  logic               in_valid,
  input  logic               in_cmd,
  input  logic [31:0]        in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output status_t            out_status,
  output logic [COUNT_W-1:0] out_count
);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data_r;
  logic [31:0]   carry_r;
  logic [31:0]   value_r;
  logic          cmd_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  status_t       status_r;
  logic          out_valid_r;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] idx_m1_a;

  assign idx_m1   = idx_r - 1'b1;
  assign idx_a    = idx_r[AW-1:0];
  assign idx_m1_a = idx_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      mem[idx_a] <= value_r;
    end else if (ctl.wr_carry) begin
      mem[idx_a] <= carry_r;
    end else if (ctl.wr_back) begin
      mem[idx_m1_a] <= rd_data_r;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[idx_a];
    end
  end

  // Hold the displaced entry while rippling upwards
  always_ff @(posedge clk) begin
    if (ctl.wr_new || ctl.wr_carry) begin
      carry_r <= rd_data_r;
    end
    if (ctl.load) begin
      value_r <= in_value;
      cmd_r   <= in_cmd;
      idx_r   <= '0;
    end else if (ctl.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (ctl.finish) begin
      status_r <= ctl.code;
    end
  end

  always_comb begin
    case (ctl.cnt_op)
      CNT_INC: count_nxt = count_r + 1'b1;
      CNT_DEC: count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.in_valid  = in_valid;
  assign st.is_remove = (cmd_r == OP_REMOVE);
  assign st.at_end    = (idx_r == count_r);
  assign st.eq        = (rd_data_r == value_r);
  assign st.gt        = ($signed(rd_data_r) > $signed(value_r));
  assign st.full      = (int'(count_r) >= CAPACITY);
  assign st.out_busy  = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  // Report the count modulo the field width
  assign out_count  = COUNT_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CAPACITY)
    else $error("entry count above capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && ctl.cnt_op == CNT_INC |-> !st.full)
    else $error("insertion into a full set");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before taken");

  a_dec_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && ctl.cnt_op == CNT_DEC |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not lower the count");

  a_back_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_back |-> idx_r != '0)
    else $error("shift down below slot zero");

endmodule

// ===== design/sus_ctrl.sv =====
// Controller: sequences search, insertion ripple and removal ripple.
module sus_ctrl import sus_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t st,
  output dp_cmd_t    ctl,
  output logic       in_ready
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (st.in_valid) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        if (!st.out_busy) begin
          if (st.is_remove) begin
            if (st.at_end || (!st.eq && st.gt)) state_nxt = S_IDLE;
            else if (st.eq) state_nxt = S_SH_RD;
            else state_nxt = S_RD;
          end else begin
            if (st.at_end || st.eq) state_nxt = S_IDLE;
            else if (st.gt) state_nxt = st.full ? S_IDLE : S_SH_RD;
            else state_nxt = S_RD;
          end
        end
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        if (!st.out_busy) begin
          state_nxt = st.at_end ? S_IDLE : S_SH_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.code   = ST_DONE;
    ctl.cnt_op = CNT_HOLD;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = st.in_valid;
      end
      S_RD: ctl.rd_en = 1'b1;
      S_EVAL: begin
        if (!st.out_busy) begin
          if (st.is_remove) begin
            if (st.at_end || (!st.eq && st.gt)) begin
              ctl.finish = 1'b1;
              ctl.code   = ST_ABSENT;
            end else begin
              ctl.idx_inc = 1'b1;
            end
          end else if (st.at_end) begin
            ctl.finish = 1'b1;
            if (st.full) begin
              ctl.code = ST_FULL;
            end else begin
              ctl.wr_new = 1'b1;
              ctl.code   = ST_DONE;
              ctl.cnt_op = CNT_INC;
            end
          end else if (st.eq) begin
            ctl.finish = 1'b1;
            ctl.code   = ST_DUP;
          end else if (st.gt) begin
            if (st.full) begin
              ctl.finish = 1'b1;
              ctl.code   = ST_FULL;
            end else begin
              // place the new value, carry the displaced entry upwards
              ctl.wr_new  = 1'b1;
              ctl.idx_inc = 1'b1;
            end
          end else begin
            ctl.idx_inc = 1'b1;
          end
        end
      end
      S_SH_RD: ctl.rd_en = 1'b1;
      S_SH_WR: begin
        if (!st.out_busy) begin
          if (st.is_remove) begin
            if (st.at_end) begin
              ctl.finish = 1'b1;
              ctl.code   = ST_DONE;
              ctl.cnt_op = CNT_DEC;
            end else begin
              ctl.wr_back = 1'b1;
              ctl.idx_inc = 1'b1;
            end
          end else begin
            ctl.wr_carry = 1'b1;
            if (st.at_end) begin
              ctl.finish = 1'b1;
              ctl.code   = ST_DONE;
              ctl.cnt_op = CNT_INC;
            end else begin
              ctl.idx_inc = 1'b1;
            end
          end
        end
      end
      default: ctl = '0;
    endcase
  end

endmodule

// ===== design/sorted_unique_set.sv =====
// Top level of the sorted unique set.
// Holds up to CAPACITY distinct signed 32-bit values in ascending order in a
// single-port memory. Each request inserts or removes one value and returns one
// result with a status (done, duplicate, absent, full) and the count held
// afterwards. Requests are handled one at a time: the controller scans the
// memory from slot zero, reading and then comparing each slot, and on a change
// ripples the entries above the position up or down, reading and then writing
// each slot. A new request is taken while the previous result waits at the
// output, but a request finishes only once that result has been taken. No
// clearing pass is needed after reset: slots at or above the count are never
// read for a result.
module sorted_unique_set import sus_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sus_in_if.sink    in_ch,
  sus_out_if.source out_ch
);

  dp_cmd_t    ctl;
  dp_status_t st;
  logic       in_ready;

  sus_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .ctl      (ctl),
    .in_ready (in_ready)
  );

  sus_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .st         (st),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_value   (in_ch.value),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_count  (out_ch.entry_count)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== sim/sus_checker.sv =====
// Checker for the sorted unique set: mirrors the held values and compares each result.
`timescale 1ns / 1ps

module sus_checker import sus_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  status_t     out_status,
  input  logic [4:0]  out_entry_count,
  output int          error_count,
  output int          results_due
);

  typedef struct packed {
    status_t    status;
    logic [4:0] entry_count;
  } outcome_t;

  logic signed [31:0] held_vals[$];
  outcome_t           due_q[$];
  int                 errors = 0;

  assign error_count = errors;

  // Apply one request to the mirrored set and return the status and count it yields.
  function automatic outcome_t predict_outcome(op_t op, logic signed [31:0] v);
    outcome_t r;
    int       pos;
    bit       found;
    pos = 0;
    while (pos < held_vals.size() && held_vals[pos] < v) pos++;
    found = (pos < held_vals.size()) && (held_vals[pos] == v);
    if (op == OP_INSERT) begin
      // a duplicate is reported ahead of a full set
      if (found) begin
        r.status = ST_DUP;
      end else if (held_vals.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        held_vals.insert(pos, v);
        r.status = ST_DONE;
      end
    end else if (!found) begin
      r.status = ST_ABSENT;
    end else begin
      held_vals.delete(pos);
      r.status = ST_DONE;
    end
    r.entry_count = 5'(held_vals.size());
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: status %0d, entry_count %0d", out_status,
                 out_entry_count);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, got %0d", want.entry_count,
                   out_entry_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) due_q.push_back(predict_outcome(op_t'(in_cmd), in_value));
    end
    results_due <= due_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// Top of the sorted unique set testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import sus_pkg::*;

  localparam int CAPACITY  = 16;
  localparam int LIMIT     = 1_000_000;
  localparam int PHASES    = 13;
  localparam int PHASE_LEN = 150;

  logic clk;
  logic rst_n;
  int   error_count;
  int   results_due;
  int   cycle_count = 0;
  bit   sender_idle = 1'b0;
  bit   stall_on    = 1'b0;

  sus_in_if  in_ch();
  sus_out_if out_ch();

  sorted_unique_set #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sus_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_cmd          (in_ch.cmd),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count),
    .error_count     (error_count),
    .results_due     (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stall bursts while enabled, otherwise always ready.
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_on) begin
        hold = 0;
      end else if (hold == 0 && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 13);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Entered and left at a falling edge; holds the request until it is taken.
  task automatic send_request(input op_t op, input logic [31:0] v);
    int gap;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] pool[32];
    int          pool_n;
    int          ins_pct;
    logic [31:0] v;
    op_t         op;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = OP_INSERT;
    in_ch.value  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty set, extremes, duplicate, absent, fill to capacity, full.
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_REMOVE, 32'h0000_0005);
    for (int i = 0; i < 11; i++) send_request(OP_INSERT, 32'(i * 7 - 40));
    send_request(OP_INSERT, 32'd100);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h7FFF_FFFF);
    send_request(OP_REMOVE, 32'h8000_0000);
    send_request(OP_REMOVE, 32'h0000_0005);

    // Hold the sender until every result is back.
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);

    // Random: per phase a pool of values, cycling through filling, mixed and draining.
    for (int phase = 0; phase < PHASES; phase++) begin
      pool_n = $urandom_range(18, 32);
      for (int i = 0; i < 32; i++) begin
        case ($urandom_range(0, 2))
          0: pool[i] = $urandom;
          1: pool[i] = $urandom_range(0, 40) - 20;
          default: begin
            if ($urandom_range(0, 1) == 1) pool[i] = 32'h8000_0000 + $urandom_range(0, 15);
            else pool[i] = 32'h7FFF_FFFF - $urandom_range(0, 15);
          end
        endcase
      end
      case (phase % 3)
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      if (phase == PHASES - 1) begin
        sender_idle = 1'b0;
        stall_on    = 1'b0;
      end else begin
        sender_idle = ($urandom_range(0, 2) != 0);
        stall_on    = ($urandom_range(0, 2) != 0);
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        op = ($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_REMOVE;
        v  = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, pool_n - 1)] : $urandom;
        send_request(op, v);
      end
    end

    in_ch.valid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
